// ----- sv/safe_area_point_clamp_macros.svh -----
// assertion macros for the safe area point clamp
`ifndef SAFE_AREA_POINT_CLAMP_MACROS_SVH
`define SAFE_AREA_POINT_CLAMP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SAP_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("safe area clamp check failed");

// next-cycle implication, clocked on clk, off during reset
`define SAP_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("safe area clamp check failed");

`endif

// ----- sv/sap_pkg.sv -----
// ----------------------------------------------------------------------------
// sap_pkg
// Types and constants shared by the safe area point clamp and its cells.
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 4;
    localparam int REG_W      = 15;
    localparam int DIFF_W     = 17;
    localparam int ROOT_W     = 17;
    localparam int SQ_W       = 35;
    localparam int NUM_W      = 32;
    localparam int QUO_W      = 15;
    localparam int WIDE_W     = 19;
    localparam int CFG_IDX_W  = 4;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int DIV_CELLS  = QUO_W;
    localparam int HALF_PIXEL = (1 << FRAC_BITS) >> 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CIRCLE_MODE = 4'd0,
        CFG_CENTRE_X    = 4'd1,
        CFG_CENTRE_Y    = 4'd2,
        CFG_SAFE_RADIUS = 4'd3,
        CFG_SAFE_LEFT   = 4'd4,
        CFG_SAFE_TOP    = 4'd5,
        CFG_SAFE_WIDTH  = 4'd6,
        CFG_SAFE_HEIGHT = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [REG_W-1:0]             object_radius;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         moved;
    } point_out_t;

    // per-item data that rides along both cell chains
    typedef struct packed {
        logic signed [DIFF_W-1:0]     dx;
        logic signed [DIFF_W-1:0]     dy;
        logic [REG_W-1:0]             r;
        logic signed [COORD_BITS-1:0] rect_x;
        logic signed [COORD_BITS-1:0] rect_y;
        logic                         rect_moved;
        logic [ROOT_W-1:0]            d;
        logic [REG_W-1:0]             lim;
        logic                         c_moved;
    } side_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        side_t           side;
    } sqrt_beat_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [QUO_W-1:0] q_x;
        logic [QUO_W-1:0] q_y;
        side_t            side;
    } div_beat_t;

endpackage

// ----- sv/sap_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// sap_sqrt_cell
// One digit step of the floor integer square root, registered.
// ----------------------------------------------------------------------------
module sap_sqrt_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          step,
    input  logic                in_valid,
    input  sap_pkg::sqrt_beat_t in_beat,
    output logic                out_valid,
    output sap_pkg::sqrt_beat_t out_beat
);
    import sap_pkg::*;

    logic             valid_reg;
    sqrt_beat_t       beat_reg;
    sqrt_beat_t       beat_next;
    logic [SQ_W-1:0]  bit_val;
    logic [SQ_W-1:0]  trial;

    // compare remainder against root plus this step's power of four
    always_comb
    begin
        bit_val   = SQ_W'(1) << {step, 1'b0};
        trial     = in_beat.root + bit_val;
        beat_next = in_beat;
        if (in_beat.rem >= trial)
        begin
            beat_next.rem  = in_beat.rem - trial;
            beat_next.root = (in_beat.root >> 1) + bit_val;
        end
        else
        begin
            beat_next.root = in_beat.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- sv/sap_div_cell.sv -----
// ----------------------------------------------------------------------------
// sap_div_cell
// One quotient bit of the two restoring dividers (x and y), registered.
// ----------------------------------------------------------------------------
module sap_div_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         step,
    input  logic               in_valid,
    input  sap_pkg::div_beat_t in_beat,
    output logic               out_valid,
    output sap_pkg::div_beat_t out_beat
);
    import sap_pkg::*;

    logic              valid_reg;
    div_beat_t         beat_reg;
    div_beat_t         beat_next;
    logic [NUM_W-1:0]  divisor;
    logic [QUO_W-1:0]  qbit;

    // subtract the shifted divisor where it fits, per axis
    always_comb
    begin
        divisor   = NUM_W'(in_beat.side.d) << step;
        qbit      = QUO_W'(1) << step;
        beat_next = in_beat;
        if (in_beat.rem_x >= divisor)
        begin
            beat_next.rem_x = in_beat.rem_x - divisor;
            beat_next.q_x   = in_beat.q_x | qbit;
        end
        if (in_beat.rem_y >= divisor)
        begin
            beat_next.rem_y = in_beat.rem_y - divisor;
            beat_next.q_y   = in_beat.q_y | qbit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- sv/safe_area_point_clamp.sv -----
// ----------------------------------------------------------------------------
// safe_area_point_clamp
// Tests an object against a circular or rectangular safe area and clamps it.
// ----------------------------------------------------------------------------
// pipeline: a start beat passes through 3 front stages, 17 square root cells,
// lim and multiply stages, 15 divider cells and the output register, and its
// result strobes on done; throughput one beat per cycle
// busy stays low; the receiver cannot stall, done lasts one cycle
// reset clears the area registers and the valid bits; data registers hold
module safe_area_point_clamp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sap_pkg::point_in_t            point,
    output logic                          done,
    output sap_pkg::point_out_t           result,
    input  logic                          wr_en,
    input  logic [sap_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [sap_pkg::REG_W-1:0]     wr_data
);
    import sap_pkg::*;
    `include "safe_area_point_clamp_macros.svh"

    // configuration registers
    logic             circle_mode_reg;
    logic [REG_W-1:0] centre_x_reg;
    logic [REG_W-1:0] centre_y_reg;
    logic [REG_W-1:0] radius_reg;
    logic [REG_W-1:0] left_reg;
    logic [REG_W-1:0] top_reg;
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circle_mode_reg <= 1'b0;
            centre_x_reg    <= '0;
            centre_y_reg    <= '0;
            radius_reg      <= '0;
            left_reg        <= '0;
            top_reg         <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_CIRCLE_MODE: circle_mode_reg <= wr_data[0];
                CFG_CENTRE_X:    centre_x_reg    <= wr_data;
                CFG_CENTRE_Y:    centre_y_reg    <= wr_data;
                CFG_SAFE_RADIUS: radius_reg      <= wr_data;
                CFG_SAFE_LEFT:   left_reg        <= wr_data;
                CFG_SAFE_TOP:    top_reg         <= wr_data;
                CFG_SAFE_WIDTH:  width_reg       <= wr_data;
                CFG_SAFE_HEIGHT: height_reg      <= wr_data;
                default:         ;
            endcase
        end
    end

    assign busy = 1'b0;

    // per-axis rectangle clamp with degenerate bounds collapsing to the middle
    function automatic logic signed [WIDE_W-1:0] clamp_axis(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [WIDE_W-1:0] edge_v,
        input logic signed [WIDE_W-1:0] size,
        input logic signed [WIDE_W-1:0] r
    );
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] res;
        lo = edge_v + r + WIDE_W'(HALF_PIXEL);
        hi = edge_v + size - r - WIDE_W'(HALF_PIXEL);
        if (lo > hi)
        begin
            lo = edge_v + (size >>> 1);
            hi = lo;
        end
        res = v;
        if (v < lo)
            res = lo;
        else if (v > hi)
            res = hi;
        return res;
    endfunction

    // saturate to the signed coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [COORD_BITS-1:0] res;
        res = v[COORD_BITS-1:0];
        if (v > WIDE_W'(signed'({1'b0, {(COORD_BITS-1){1'b1}}})))
            res = {1'b0, {(COORD_BITS-1){1'b1}}};
        else if (v < -WIDE_W'(signed'({1'b0, {(COORD_BITS-1){1'b1}}})) - WIDE_W'(1))
            res = {1'b1, {(COORD_BITS-1){1'b0}}};
        return res;
    endfunction

    // stage 0: differences from the centre and the whole rectangle path
    logic                     s0_v_reg;
    side_t                    s0_reg;
    side_t                    s0_next;
    logic signed [WIDE_W-1:0] wx;
    logic signed [WIDE_W-1:0] wy;
    logic signed [WIDE_W-1:0] wr;
    logic signed [WIDE_W-1:0] wl;
    logic signed [WIDE_W-1:0] wt;
    logic signed [WIDE_W-1:0] ww;
    logic signed [WIDE_W-1:0] wh;
    logic                     rect_in;

    always_comb
    begin
        wx = WIDE_W'(point.point_x);
        wy = WIDE_W'(point.point_y);
        wr = WIDE_W'(signed'({1'b0, point.object_radius}));
        wl = WIDE_W'(signed'({1'b0, left_reg}));
        wt = WIDE_W'(signed'({1'b0, top_reg}));
        ww = WIDE_W'(signed'({1'b0, width_reg}));
        wh = WIDE_W'(signed'({1'b0, height_reg}));
        rect_in = (wx - wr >= wl) && (wx + wr <= wl + ww) &&
                  (wy - wr >= wt) && (wy + wr <= wt + wh);
        s0_next            = '0;
        s0_next.dx         = DIFF_W'(point.point_x) - DIFF_W'(signed'({1'b0, centre_x_reg}));
        s0_next.dy         = DIFF_W'(point.point_y) - DIFF_W'(signed'({1'b0, centre_y_reg}));
        s0_next.r          = point.object_radius;
        s0_next.rect_moved = !rect_in;
        s0_next.rect_x     = point.point_x;
        s0_next.rect_y     = point.point_y;
        if (!rect_in)
        begin
            s0_next.rect_x = sat_coord(clamp_axis(wx, wl, ww, wr));
            s0_next.rect_y = sat_coord(clamp_axis(wy, wt, wh, wr));
        end
    end

    // stage 1: squares of the magnitudes
    logic              s1_v_reg;
    side_t             s1_reg;
    logic [DIFF_W-1:0] mag_x;
    logic [DIFF_W-1:0] mag_y;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;

    assign mag_x = s0_reg.dx[DIFF_W-1] ? DIFF_W'(-s0_reg.dx) : DIFF_W'(s0_reg.dx);
    assign mag_y = s0_reg.dy[DIFF_W-1] ? DIFF_W'(-s0_reg.dy) : DIFF_W'(s0_reg.dy);

    // stage 2: sum of squares, loaded into the root chain
    logic       s2_v_reg;
    sqrt_beat_t s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= start && !busy;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg      <= s0_next;
        s1_reg      <= s0_reg;
        sqx_reg     <= SQ_W'(mag_x * mag_x);
        sqy_reg     <= SQ_W'(mag_y * mag_y);
        s2_reg.rem  <= sqx_reg + sqy_reg;
        s2_reg.root <= '0;
        s2_reg.side <= s1_reg;
    end

    // square root chain, most significant digit first
    logic       sq_v [0:SQRT_CELLS];
    sqrt_beat_t sq_b [0:SQRT_CELLS];

    assign sq_v[0] = s2_v_reg;
    assign sq_b[0] = s2_reg;

    for (genvar j = 0; j < SQRT_CELLS; j++)
    begin : g_sqrt
        sap_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (5'(SQRT_CELLS - 1 - j)),
            .in_valid  (sq_v[j]),
            .in_beat   (sq_b[j]),
            .out_valid (sq_v[j+1]),
            .out_beat  (sq_b[j+1])
        );
    end

    // stage 3: inside test and clamp radius
    logic                     s3_v_reg;
    side_t                    s3_reg;
    side_t                    s3_next;
    logic [ROOT_W-1:0]        root_d;
    logic [ROOT_W:0]          dr_sum;
    logic signed [ROOT_W-1:0] lim_raw;

    always_comb
    begin
        root_d  = sq_b[SQRT_CELLS].root[ROOT_W-1:0];
        dr_sum  = (ROOT_W+1)'(root_d) + (ROOT_W+1)'(sq_b[SQRT_CELLS].side.r);
        lim_raw = ROOT_W'(radius_reg) - ROOT_W'(sq_b[SQRT_CELLS].side.r)
                  - ROOT_W'(HALF_PIXEL);
        s3_next         = sq_b[SQRT_CELLS].side;
        s3_next.d       = root_d;
        s3_next.c_moved = dr_sum > (ROOT_W+1)'(radius_reg);
        s3_next.lim     = lim_raw[ROOT_W-1] ? '0 : lim_raw[REG_W-1:0];
    end

    // stage 4: numerators |dx| * lim and |dy| * lim
    logic              s4_v_reg;
    div_beat_t         s4_reg;
    logic [DIFF_W-1:0] mag3_x;
    logic [DIFF_W-1:0] mag3_y;

    assign mag3_x = s3_reg.dx[DIFF_W-1] ? DIFF_W'(-s3_reg.dx) : DIFF_W'(s3_reg.dx);
    assign mag3_y = s3_reg.dy[DIFF_W-1] ? DIFF_W'(-s3_reg.dy) : DIFF_W'(s3_reg.dy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            s3_v_reg <= sq_v[SQRT_CELLS];
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg       <= s3_next;
        s4_reg.rem_x <= NUM_W'(mag3_x * s3_reg.lim);
        s4_reg.rem_y <= NUM_W'(mag3_y * s3_reg.lim);
        s4_reg.q_x   <= '0;
        s4_reg.q_y   <= '0;
        s4_reg.side  <= s3_reg;
    end

    // divider chain, most significant quotient bit first
    logic      dv_v [0:DIV_CELLS];
    div_beat_t dv_b [0:DIV_CELLS];

    assign dv_v[0] = s4_v_reg;
    assign dv_b[0] = s4_reg;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        sap_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (4'(DIV_CELLS - 1 - j)),
            .in_valid  (dv_v[j]),
            .in_beat   (dv_b[j]),
            .out_valid (dv_v[j+1]),
            .out_beat  (dv_b[j+1])
        );
    end

    // final: sign the quotients, offset by the centre, pick the mode
    div_beat_t                fin;
    logic signed [WIDE_W-1:0] qx;
    logic signed [WIDE_W-1:0] qy;
    logic signed [WIDE_W-1:0] cxw;
    logic signed [WIDE_W-1:0] cyw;
    logic signed [WIDE_W-1:0] circ_x;
    logic signed [WIDE_W-1:0] circ_y;
    point_out_t               res_next;
    point_out_t               res_reg;
    logic                     done_reg;

    always_comb
    begin
        fin = dv_b[DIV_CELLS];
        qx  = WIDE_W'(signed'({1'b0, fin.q_x}));
        qy  = WIDE_W'(signed'({1'b0, fin.q_y}));
        if (fin.side.dx[DIFF_W-1])
            qx = -qx;
        if (fin.side.dy[DIFF_W-1])
            qy = -qy;
        cxw = WIDE_W'(signed'({1'b0, centre_x_reg}));
        cyw = WIDE_W'(signed'({1'b0, centre_y_reg}));
        if (fin.side.d == '0)
        begin
            circ_x = cxw;
            circ_y = cyw - WIDE_W'(signed'({1'b0, fin.side.lim}));
        end
        else
        begin
            circ_x = cxw + qx;
            circ_y = cyw + qy;
        end
        res_next.out_x = fin.side.rect_x;
        res_next.out_y = fin.side.rect_y;
        res_next.moved = fin.side.rect_moved;
        if (circle_mode_reg)
        begin
            res_next.moved = fin.side.c_moved;
            res_next.out_x = fin.side.c_moved ? sat_coord(circ_x)
                                              : COORD_BITS'(fin.side.dx + DIFF_W'(cxw));
            res_next.out_y = fin.side.c_moved ? sat_coord(circ_y)
                                              : COORD_BITS'(fin.side.dy + DIFF_W'(cyw));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v[DIV_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // checks
    `SAP_ASSERT_NXT(a_front_load, start && !busy, s0_v_reg)
    `SAP_ASSERT_NXT(a_done_follows, dv_v[DIV_CELLS], done)
    `SAP_ASSERT_IMP(a_quot_bound, dv_v[DIV_CELLS] && (fin.side.d != '0),
                    (fin.q_x <= fin.side.lim) && (fin.q_y <= fin.side.lim))

endmodule
